// ----- hw/rtl/ces_pkg.sv -----
// Shared types and codes for the coalescing event stack.
// Used by ces_ctrl, ces_datapath and coalescing_event_stack; no dependencies.
package ces_pkg;

	// item operation codes
	localparam logic [1:0] OP_PUSH  = 2'd0;
	localparam logic [1:0] OP_POP   = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// message kinds
	localparam logic [2:0] MK_ACTION = 3'd0;
	localparam logic [2:0] MK_ROTATE = 3'd1;
	localparam logic [2:0] MK_KEY    = 3'd2;
	localparam logic [2:0] MK_UPDATE = 3'd3;
	localparam logic [2:0] MK_CLOSE  = 3'd4;
	localparam logic [2:0] MK_NONE   = 3'd5;

	localparam logic [7:0]         TYPE_NONACTION = 8'hFF;
	localparam logic signed [31:0] VALUE_NOARG    = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic [1:0]         kind;
		logic [2:0]         msg_kind;
		logic [7:0]         obj_type;
		logic signed [31:0] value;
	} ces_in_t;

	typedef struct packed {
		logic               accepted;
		logic [2:0]         pop_kind;
		logic [7:0]         pop_type;
		logic signed [31:0] pop_value;
		logic [4:0]         fill_count;
	} ces_out_t;

	typedef struct packed {
		logic [2:0]         kind;
		logic [7:0]         obj_type;
		logic signed [31:0] value;
	} ces_entry_t;

	typedef struct packed {
		logic capture;
		logic execute;
	} ces_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} ces_state_t;

endpackage

// ----- hw/rtl/coalescing_event_stack.sv -----
// Top level of the coalescing event stack: controller plus datapath.
// Depends on ces_pkg, ces_ctrl and ces_datapath.
//
// An item is taken when start is high while busy is low; busy then stays high for one
// cycle while the top entry, read from the entry memory at the accept edge, is compared,
// merged or replaced. Exactly one result follows per item, shown on rsp for a single
// cycle with done high, in the first cycle with busy low again; the receiver cannot
// stall it, so it must capture rsp whenever done is high. A new item may be started in
// that same cycle. Clear and reset take effect at once through the fill count; there is
// no clearing pass.
module coalescing_event_stack #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  ces_pkg::ces_in_t  req,
	output logic              done,
	output ces_pkg::ces_out_t rsp
);
	import ces_pkg::*;

	ces_cmd_t cmd;

	ces_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd)
	);

	ces_datapath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

endmodule

// ----- hw/rtl/ces_ctrl.sv -----
// Controller for the coalescing event stack: idle/execute sequencing and result strobe.
// Depends on ces_pkg.
module ces_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	output logic              done,
	output ces_pkg::ces_cmd_t cmd
);
	import ces_pkg::*;

	ces_state_t state_q;
	ces_state_t state_nxt;
	logic       done_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_nxt = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd.capture = 1'b0;
		cmd.execute = 1'b0;
		busy        = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = start;
			end
			ST_EXEC: begin
				cmd.execute = 1'b1;
				busy        = 1'b1;
			end
			default: begin
				busy = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			done_q  <= cmd.execute;
		end
	end

	assign done = done_q;

endmodule

// ----- hw/rtl/ces_datapath.sv -----
// Datapath for the coalescing event stack: entry memory, fill count and push/pop logic.
// Depends on ces_pkg.
module ces_datapath #(
	parameter int STACK_DEPTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  ces_pkg::ces_cmd_t cmd,
	input  ces_pkg::ces_in_t  req,
	output ces_pkg::ces_out_t rsp
);
	import ces_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);

	ces_entry_t mem [STACK_DEPTH];

	ces_in_t    item_q;
	ces_entry_t top_s1;
	logic [CW-1:0] count_q;
	ces_out_t   rsp_q;

	logic [AW-1:0] top_addr;
	logic [AW-1:0] push_addr;
	logic          has_top;
	logic          full;

	logic          wr_en;
	logic [AW-1:0] wr_addr;
	ces_entry_t    wr_data;
	logic [CW-1:0] count_nxt;
	ces_out_t      rsp_nxt;

	assign top_addr  = AW'(count_q - CW'(1));
	assign push_addr = AW'(count_q);
	assign has_top   = (count_q != '0);
	assign full      = (count_q >= CW'(STACK_DEPTH));

	always_comb begin
		wr_en      = 1'b0;
		wr_addr    = push_addr;
		wr_data    = '{kind: item_q.msg_kind, obj_type: TYPE_NONACTION, value: item_q.value};
		count_nxt  = count_q;
		rsp_nxt    = '{accepted: 1'b0, pop_kind: MK_NONE, pop_type: 8'd0,
			pop_value: 32'sd0, fill_count: 5'd0};

		unique case (item_q.kind)
			OP_PUSH: begin
				if (item_q.msg_kind <= MK_CLOSE && !full) begin
					rsp_nxt.accepted = 1'b1;
					unique case (item_q.msg_kind)
						MK_ACTION: begin
							// drop an exact repeat of the top action
							if (!(has_top && top_s1.kind == MK_ACTION &&
								top_s1.obj_type == item_q.obj_type &&
								top_s1.value == item_q.value)) begin
								wr_en            = 1'b1;
								wr_data.obj_type = item_q.obj_type;
							end
						end
						MK_ROTATE: begin
							wr_en = 1'b1;
							if (has_top && top_s1.kind == MK_ROTATE) begin
								// merge into the top rotation, wrapping at 32 bits
								wr_addr       = top_addr;
								wr_data.value = top_s1.value + item_q.value;
							end
						end
						MK_KEY: begin
							wr_en = 1'b1;
						end
						default: begin
							if (!(has_top && top_s1.kind == item_q.msg_kind)) begin
								wr_en         = 1'b1;
								wr_data.value = VALUE_NOARG;
							end
						end
					endcase
					if (wr_en && wr_addr == push_addr) begin
						count_nxt = count_q + CW'(1);
					end
				end
			end
			OP_POP: begin
				if (has_top) begin
					rsp_nxt.pop_kind  = top_s1.kind;
					rsp_nxt.pop_type  = top_s1.obj_type;
					rsp_nxt.pop_value = top_s1.value;
					count_nxt         = count_q - CW'(1);
				end
			end
			OP_CLEAR: begin
				count_nxt = '0;
			end
			default: begin
			end
		endcase

		rsp_nxt.fill_count = 5'(count_nxt);
	end

	// registered read of the current top every cycle
	always_ff @(posedge clk) begin
		top_s1 <= mem[top_addr];
		if (cmd.execute && wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= req;
		end
		if (cmd.execute) begin
			rsp_q <= rsp_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.execute) begin
			count_q <= count_nxt;
		end
	end

	assign rsp = rsp_q;

endmodule
